>>> hdl/interpolated_correction_table_defines.svh
// assertion macros for the interpolated correction table checker
`ifndef INTERPOLATED_CORRECTION_TABLE_DEFINES_SVH
`define INTERPOLATED_CORRECTION_TABLE_DEFINES_SVH

// clocked on clk_i, switched off while rst_ni is low
`define ICT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ict assertion failed");

// clocked on clk_i, also checked through reset
`define ICT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("ict assertion failed");

`endif

>>> hdl/ict_pkg.sv
// types, constants and codes shared by the correction table design
package ict_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);
  localparam int unsigned RadW       = 24;
  localparam int unsigned DataW      = 32;
  localparam int unsigned WgtW       = 33;
  localparam int unsigned NumW       = 66;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpLoad  = 2'd1,
    OpQuery = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadRadius = 3'd1,
    StWrongSign = 3'd2,
    StNoCorr    = 3'd3,
    StFull      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CfgRadius      = 2'd0,
    CfgRadiusBelow = 2'd1,
    CfgRadiusAbove = 2'd2,
    CfgRadiusSet   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [31:0] eta;
    logic signed [31:0] corr_low_radius;
    logic signed [31:0] corr_high_radius;
  } ict_in_t;

  typedef struct packed {
    logic signed [31:0] correction;
    logic [2:0]         status;
  } ict_out_t;

endpackage

>>> hdl/interpolated_correction_table.sv
// top level: piecewise-linear correction table with binary search lookup
//
//  channel   | signals                              | transfer
//  ----------+--------------------------------------+---------------------------
//  input     | in_valid_i, in_ready_o, in_data_i    | valid and ready both high
//  output    | out_valid_o, out_ready_i, out_data_o | valid and ready both high
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i      | write enable high
//
//  one transaction at a time; clear and unused opcodes go straight to the output state
//  a load goes straight to multiply, sum and divide; a full query first checks the sign
//  and end keys and runs the binary search; both use the 65-step shift-subtract divider
//  reset empties the table and clears the config registers; no clearing pass
//  a new transaction is taken while the previous result waits in the output register
module interpolated_correction_table import ict_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ict_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ict_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [RadW-1:0]   cfg_data_i
);

  typedef enum logic [12:0] {
    SIdle  = 13'h0001,
    SMid   = 13'h0002,
    SFirst = 13'h0004,
    SLast  = 13'h0008,
    SSrch  = 13'h0010,
    SPair0 = 13'h0020,
    SPair1 = 13'h0040,
    SPair2 = 13'h0080,
    SMul1  = 13'h0100,
    SMul2  = 13'h0200,
    SSum   = 13'h0400,
    SDiv   = 13'h0800,
    SOut   = 13'h1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [RadW-1:0] radius_q, radius_below_q, radius_above_q;
  logic            radius_set_q;

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  ict_out_t          out_q, out_d, res_q, res_d;

  // working registers of the current transaction
  logic signed [31:0]     eta_q, eta_d, kfirst_q, kfirst_d, cfirst_q, cfirst_d;
  logic signed [31:0]     khi_q, khi_d, ca_q, ca_d, cb_q, cb_d;
  logic [WgtW-1:0]        wa_q, wa_d, wb_q, wb_d, den_q, den_d;
  logic signed [NumW-1:0] p1_q, p1_d, p2_q, p2_d;
  logic [AddrW-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                   query_q, query_d;

  // memory ports
  logic [AddrW-1:0]   raddr;
  logic               mem_we;
  logic signed [31:0] rd_key, rd_corr;

  // divider
  logic                   div_start, div_done;
  logic signed [NumW-1:0] num;
  logic signed [31:0]     quot;

  // search step
  logic [AddrW-1:0]  last_idx, srch_lo, srch_hi, srch_mid;
  logic              key_lt;
  logic [CountW-1:0] lo_plus1;
  logic signed [32:0] eta_x, rk_x, khi_x;

  assign last_idx = AddrW'(count_q - 1'b1);
  assign key_lt   = rd_key < eta_q;
  assign srch_lo  = key_lt ? lo_q : AddrW'(lo_q + mid_q);
  assign srch_hi  = key_lt ? AddrW'(hi_q - mid_q) : hi_q;
  assign srch_mid = AddrW'((srch_hi - srch_lo) >> 1);
  assign lo_plus1 = CountW'(lo_q) + 1'b1;
  assign eta_x    = {eta_q[31], eta_q};
  assign rk_x     = {rd_key[31], rd_key};
  assign khi_x    = {khi_q[31], khi_q};
  assign num      = p1_q + p2_q;

  ict_ram #(.Width(DataW), .Depth(TableDepth)) u_keys (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(count_q)),
    .wdata_i (eta_q),
    .raddr_i (raddr),
    .rdata_o (rd_key)
  );

  ict_ram #(.Width(DataW), .Depth(TableDepth)) u_corrs (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(count_q)),
    .wdata_i (quot),
    .raddr_i (raddr),
    .rdata_o (rd_corr)
  );

  ict_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign in_ready_o = (state_q == SIdle);

  // read address: each state asks for the entry the next state consumes
  always_comb begin
    unique case (state_q)
      SIdle:   raddr = AddrW'(last_idx >> 1);
      SMid:    raddr = '0;
      SFirst:  raddr = last_idx;
      SLast:   raddr = AddrW'(last_idx >> 1);
      SSrch:   raddr = AddrW'(srch_lo + srch_mid);
      SPair0:  raddr = lo_q;
      SPair1:  raddr = AddrW'(lo_q + 1'b1);
      default: raddr = lo_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    res_d       = res_q;
    eta_d       = eta_q;
    kfirst_d    = kfirst_q;
    cfirst_d    = cfirst_q;
    khi_d       = khi_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    den_d       = den_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    query_d     = query_q;
    div_start   = 1'b0;
    mem_we      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          eta_d   = in_data_i.eta;
          query_d = (in_data_i.opcode == OpQuery);
          res_d   = '{correction: '0, status: StOk};
          state_d = SOut;
          unique case (op_e'(in_data_i.opcode))
            OpClear: count_d = '0;
            OpLoad: begin
              if (!radius_set_q || radius_q < radius_below_q ||
                  radius_q > radius_above_q || radius_above_q == radius_below_q) begin
                res_d.status = StBadRadius;
              end else if (count_q >= CountW'(TableDepth)) begin
                res_d.status = StFull;
              end else begin
                // weight of the upper radius correction grows with the radius
                wa_d    = WgtW'(radius_q - radius_below_q);
                ca_d    = in_data_i.corr_high_radius;
                wb_d    = WgtW'(radius_above_q - radius_q);
                cb_d    = in_data_i.corr_low_radius;
                den_d   = WgtW'(radius_above_q - radius_below_q);
                state_d = SMul1;
              end
            end
            OpQuery: begin
              if (!radius_set_q) begin
                res_d.status = StBadRadius;
              end else if (count_q == '0) begin
                res_d.status = StNoCorr;
              end else begin
                state_d = SMid;
              end
            end
            OpNone: ;
            default: ;
          endcase
        end
      end
      SMid: begin
        // sign check against the middle key
        if ((eta_q < 0 && rd_key > 0) || (eta_q > 0 && rd_key < 0)) begin
          res_d   = '{correction: '0, status: StWrongSign};
          state_d = SOut;
        end else begin
          state_d = SFirst;
        end
      end
      SFirst: begin
        kfirst_d = rd_key;
        cfirst_d = rd_corr;
        state_d  = SLast;
      end
      SLast: begin
        lo_d  = '0;
        hi_d  = last_idx;
        mid_d = AddrW'(last_idx >> 1);
        if (eta_q > kfirst_q && kfirst_q > 0) begin
          res_d   = '{correction: cfirst_q, status: StOk};
          state_d = SOut;
        end else if (eta_q < rd_key && rd_key < 0) begin
          res_d   = '{correction: rd_corr, status: StOk};
          state_d = SOut;
        end else if ((last_idx >> 1) == '0) begin
          state_d = SPair0;
        end else begin
          state_d = SSrch;
        end
      end
      SSrch: begin
        // descending table: a smaller key means eta lies above it
        lo_d  = srch_lo;
        hi_d  = srch_hi;
        mid_d = srch_mid;
        if (srch_mid == '0) begin
          state_d = SPair0;
        end
      end
      SPair0: begin
        if (lo_plus1 >= count_q) begin
          res_d   = '{correction: '0, status: StNoCorr};
          state_d = SOut;
        end else begin
          state_d = SPair1;
        end
      end
      SPair1: begin
        khi_d   = rd_key;
        ca_d    = rd_corr;
        state_d = SPair2;
      end
      SPair2: begin
        cb_d = rd_corr;
        wa_d = WgtW'(eta_x - rk_x);
        wb_d = WgtW'(khi_x - eta_x);
        den_d = WgtW'(khi_x - rk_x);
        if (!(khi_q >= eta_q && eta_q >= rd_key)) begin
          res_d   = '{correction: '0, status: StNoCorr};
          state_d = SOut;
        end else if (khi_q == rd_key) begin
          res_d   = '{correction: '0, status: StBadRadius};
          state_d = SOut;
        end else begin
          state_d = SMul1;
        end
      end
      SMul1: begin
        p1_d    = NumW'($signed({1'b0, wa_q}) * ca_q);
        state_d = SMul2;
      end
      SMul2: begin
        p2_d    = NumW'($signed({1'b0, wb_q}) * cb_q);
        state_d = SSum;
      end
      SSum: begin
        if (query_q && num < 0) begin
          res_d   = '{correction: '0, status: StNoCorr};
          state_d = SOut;
        end else begin
          div_start = 1'b1;
          state_d   = SDiv;
        end
      end
      SDiv: begin
        if (div_done) begin
          // a load appends its key and value at the fill point
          if (!query_q) begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
          res_d   = '{correction: quot, status: StOk};
          state_d = SOut;
        end
      end
      SOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SIdle;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
      radius_q       <= '0;
      radius_below_q <= '0;
      radius_above_q <= '0;
      radius_set_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgRadius:      radius_q       <= cfg_data_i;
          CfgRadiusBelow: radius_below_q <= cfg_data_i;
          CfgRadiusAbove: radius_above_q <= cfg_data_i;
          CfgRadiusSet:   radius_set_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    res_q    <= res_d;
    eta_q    <= eta_d;
    kfirst_q <= kfirst_d;
    cfirst_q <= cfirst_d;
    khi_q    <= khi_d;
    ca_q     <= ca_d;
    cb_q     <= cb_d;
    wa_q     <= wa_d;
    wb_q     <= wb_d;
    den_q    <= den_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    query_q  <= query_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/ict_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module ict_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/ict_div.sv
// rounded signed-by-unsigned divider, one quotient bit per cycle
module ict_div import ict_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [WgtW-1:0]        den_i,
  output logic                   done_o,
  output logic signed [31:0]     quot_o
);

  localparam int unsigned DvdW = NumW - 1;
  localparam int unsigned CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [WgtW-1:0] rem_q, rem_d, den_q;
  logic [31:0]     quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, neg_q, done_q, done_d;
  logic [NumW-1:0] mag;
  logic [WgtW:0]   rem_sh;

  // magnitude plus half the divisor gives round half away from zero
  assign mag    = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
  assign rem_sh = {rem_q, dvd_q[DvdW-1]};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = mag[DvdW-1:0] + DvdW'(den_i >> 1);
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(DvdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = WgtW'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[WgtW-1:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[NumW-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

>>> hdl/ict_checker.sv
// port-level checker for the correction table, bound to the top level
`include "interpolated_correction_table_defines.svh"

module ict_port_checker import ict_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input ict_in_t         in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input ict_out_t        out_data_o,
  input logic            cfg_we_i,
  input logic [1:0]      cfg_idx_i,
  input logic [RadW-1:0] cfg_data_i
);

  `ICT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  `ICT_ASSERT(a_err_zero, out_valid_o && out_data_o.status != StOk |-> out_data_o.correction == 0)
  `ICT_ASSERT(a_out_after_busy, $rose(out_valid_o) |-> !$past(in_ready_o))
  `ICT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o && in_ready_o)

endmodule

bind interpolated_correction_table ict_port_checker u_ict_checker (.*);
